>>> hw/rtl/tftpwr_pkg.sv
package tftpwr_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int HDR_BYTES   = 4;
    localparam int REQ_MIN_LEN = 6;

    localparam int LEN_W  = 10;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 8;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [WORD_W-1:0] REQ_OPCODE = 16'd2;
    localparam logic [WORD_W-1:0] DAT_OPCODE = 16'd3;
    localparam logic [CNT_W-1:0]  FAIL_LIMIT_RST = 8'd7;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_CONTINUE = 2'd1,
        ST_DONE     = 2'd2,
        ST_ABORT    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_OPCODE   = 3'd2,
        ERR_BLOCK    = 3'd3,
        ERR_NAME     = 3'd4,
        ERR_MODE     = 3'd5,
        ERR_TIMEOUTS = 3'd6
    } t_err;

    typedef struct packed {
        logic              op;
        logic [LEN_W-1:0]  pkt_len;
        logic [WORD_W-1:0] pkt_opcode;
        logic [WORD_W-1:0] data_blk;
        logic [LEN_W-1:0]  name_len;
        logic [LEN_W-1:0]  mode_len;
    } t_item;

    typedef struct packed {
        logic              ack_send;
        logic [WORD_W-1:0] ack_block;
        logic              write_en;
        logic [LEN_W-1:0]  write_len;
        t_status           status;
        t_err              error_code;
    } t_result;

    typedef struct packed {
        logic              active;
        logic [WORD_W-1:0] ack_count;
        logic [CNT_W-1:0]  timeout_count;
    } t_sess;

endpackage

>>> hw/rtl/tftpwr_decide.sv
module tftpwr_decide (
    input  tftpwr_pkg::t_item              i_item,
    input  tftpwr_pkg::t_sess              i_sess,
    input  logic [tftpwr_pkg::CNT_W-1:0]   i_limit,
    output tftpwr_pkg::t_result            o_res,
    output tftpwr_pkg::t_sess              o_sess
);
    import tftpwr_pkg::*;

    logic [LEN_W:0]    len_m4;
    logic [LEN_W:0]    mode_room;
    logic [WORD_W:0]   next_blk;
    logic [WORD_W-1:0] ack_inc;
    logic [CNT_W-1:0]  tc_inc;
    t_err              err;

    assign len_m4    = {1'b0, i_item.pkt_len} - (LEN_W+1)'(HDR_BYTES);
    assign mode_room = len_m4 - {1'b0, i_item.name_len};
    assign next_blk  = {1'b0, i_sess.ack_count} + (WORD_W+1)'(1);
    assign ack_inc   = next_blk[WORD_W-1:0];
    assign tc_inc    = i_sess.timeout_count + CNT_W'(1);

    always_comb begin
        o_res  = '0;
        o_sess = i_sess;
        err    = ERR_NONE;
        if (i_item.op) begin
            if (i_sess.active) begin
                o_res.ack_send  = 1'b1;
                o_res.ack_block = i_sess.ack_count;
                if (tc_inc >= i_limit) begin
                    o_res.status     = ST_ABORT;
                    o_res.error_code = ERR_TIMEOUTS;
                    o_sess           = '0;
                end else begin
                    o_res.status         = ST_CONTINUE;
                    o_sess.timeout_count = tc_inc;
                end
            end
        end else if (!i_sess.active) begin
            if (i_item.pkt_len < LEN_W'(REQ_MIN_LEN)) begin
                err = ERR_LENGTH;
            end else if (i_item.pkt_opcode != REQ_OPCODE) begin
                err = ERR_OPCODE;
            end else if (i_item.name_len == '0 || {1'b0, i_item.name_len} >= len_m4) begin
                err = ERR_NAME;
            end else if (i_item.mode_len == '0 || {1'b0, i_item.mode_len} > mode_room) begin
                err = ERR_MODE;
            end
            if (err != ERR_NONE) begin
                o_res.status     = ST_ABORT;
                o_res.error_code = err;
                o_sess           = '0;
            end else begin
                o_res.ack_send = 1'b1;
                o_res.status   = ST_CONTINUE;
                o_sess         = '{active: 1'b1, ack_count: '0, timeout_count: '0};
            end
        end else begin
            o_sess.timeout_count = '0;
            if (i_item.pkt_len < LEN_W'(HDR_BYTES) ||
                i_item.pkt_len > LEN_W'(BLOCK_BYTES + HDR_BYTES)) begin
                err = ERR_LENGTH;
            end else if (i_item.pkt_opcode != DAT_OPCODE) begin
                err = ERR_OPCODE;
            end else if ({1'b0, i_item.data_blk} != next_blk) begin
                err = ERR_BLOCK;
            end
            if (err != ERR_NONE) begin
                o_res.status     = ST_ABORT;
                o_res.error_code = err;
                o_sess           = '0;
            end else begin
                o_res.ack_send  = 1'b1;
                o_res.ack_block = ack_inc;
                o_res.write_en  = 1'b1;
                o_res.write_len = len_m4[LEN_W-1:0];
                if (i_item.pkt_len < LEN_W'(BLOCK_BYTES + HDR_BYTES)) begin
                    o_res.status = ST_DONE;
                    o_sess       = '0;
                end else begin
                    o_res.status     = ST_CONTINUE;
                    o_sess.ack_count = ack_inc;
                end
            end
        end
    end

endmodule

>>> hw/rtl/tftpwr_session.sv
module tftpwr_session (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_update,
    input  tftpwr_pkg::t_sess              i_sess_nxt,
    input  logic                           i_cfg_valid,
    input  logic [tftpwr_pkg::CNT_W-1:0]   i_cfg_data,
    output tftpwr_pkg::t_sess              o_sess,
    output logic [tftpwr_pkg::CNT_W-1:0]   o_limit
);
    import tftpwr_pkg::*;

    t_sess            r_sess;
    logic [CNT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess  <= '0;
            r_limit <= FAIL_LIMIT_RST;
        end else begin
            if (i_update) begin
                r_sess <= i_sess_nxt;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    assign o_sess  = r_sess;
    assign o_limit = r_limit;

endmodule

>>> hw/rtl/tftp_write_receiver_core.sv
// TFTP write-request receiver core.
// Slave stream: one beat per event. tuser = op (0 packet summary, 1 timeout
// tick); tdata carries the packet summary fields.
// Master stream: one result beat per accepted input beat, in order.
// Config channel: i_cfg_valid/o_cfg_ready/i_cfg_data sets the consecutive
// timeout limit (reset 7); o_cfg_ready is always high. Write it only idle.
// Path: a beat accepted into the input register goes through the decision
// logic into the result register, which drives m_tvalid.
// Throughput: one beat per cycle while m_tready is high; session state is updated in the same
// cycle the decision logic moves an item into the result register.
// Stall: when m_tready is low the result holds; one more beat is buffered
// in the input register, then s_tready drops.
// Reset (synchronous, active low): session idle, counters cleared, both
// registers empty, limit back to 7.
module tftp_write_receiver_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tftpwr_pkg::IN_TDATA_W-1:0]   s_tdata,  // pkt_len[9:0], pkt_opcode[25:10],
                                                          // data_blk[41:26], name_len[51:42],
                                                          // mode_len[61:52], zero[63:62]
    input  logic                                s_tuser,  // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tftpwr_pkg::OUT_TDATA_W-1:0]  m_tdata,  // ack_send[0], ack_block[16:1],
                                                          // write_en[17], write_len[27:18],
                                                          // status[29:28],
                                                          // error_code[32:30], zero[39:33]
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tftpwr_pkg::CNT_W-1:0]        i_cfg_data
);
    import tftpwr_pkg::*;

    logic             r_in_valid;
    t_item            r_item;
    logic             r_out_valid;
    t_result          r_res;
    logic             out_free;
    logic             advance;
    t_sess            sess;
    t_sess            n_sess;
    t_result          n_res;
    logic [CNT_W-1:0] limit;

    assign out_free    = !r_out_valid || m_tready;
    assign advance     = r_in_valid && out_free;
    assign s_tready    = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item <= '{op:         s_tuser,
                        pkt_len:    s_tdata[9:0],
                        pkt_opcode: s_tdata[25:10],
                        data_blk:   s_tdata[41:26],
                        name_len:   s_tdata[51:42],
                        mode_len:   s_tdata[61:52]};
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    tftpwr_decide u_decide (
        .i_item (r_item),
        .i_sess (sess),
        .i_limit(limit),
        .o_res  (n_res),
        .o_sess (n_sess)
    );

    tftpwr_session u_session (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (advance),
        .i_sess_nxt (n_sess),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_sess     (sess),
        .o_limit    (limit)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_res.error_code, r_res.status, r_res.write_len,
                       r_res.write_en, r_res.ack_block, r_res.ack_send};

endmodule

>>> hw/rtl/tftpwr_checker.sv
module tftpwr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tftpwr_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tftpwr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_abort_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((m_tdata[29:28] == ST_ABORT) == (m_tdata[32:30] != ERR_NONE)))
        else $error("status and error code disagree");

    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[17] |-> m_tdata[0] && m_tdata[29:28] != ST_ABORT)
        else $error("write without ack");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready && !s_tready |=> !m_tvalid || !$past(s_tvalid) ||
            $stable(m_tdata))
        else $error("input taken while full");

endmodule

bind tftp_write_receiver_core tftpwr_checker u_tftpwr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> bench/tftp_write_receiver_core_tb.sv
module tftp_write_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tftpwr_pkg::*;

    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;
    localparam int   FULL_LEN   = BLOCK_BYTES + HDR_BYTES;

    // Tracks the write session and holds the results still owed by the block.
    class session_tracker;
        logic              active;
        logic [WORD_W-1:0] acked;
        logic [CNT_W-1:0]  timeouts;
        logic [CNT_W-1:0]  limit;
        t_result           due_results[$];
        int                mismatch_count;

        function new();
            active         = 1'b0;
            acked          = '0;
            timeouts       = '0;
            limit          = FAIL_LIMIT_RST;
            mismatch_count = 0;
        endfunction

        function void set_limit(logic [CNT_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void end_session();
            active   = 1'b0;
            acked    = '0;
            timeouts = '0;
        endfunction

        function void note_item(t_item it);
            t_result r;
            t_err    err;
            int      l;
            int      n;
            int      m;
            r   = '0;
            err = ERR_NONE;
            l   = int'(it.pkt_len);
            n   = int'(it.name_len);
            m   = int'(it.mode_len);
            if (it.op == OP_TIMEOUT) begin
                if (active) begin
                    timeouts    = timeouts + 1'b1;
                    r.ack_send  = 1'b1;
                    r.ack_block = acked;
                    if (timeouts >= limit) begin
                        r.status     = ST_ABORT;
                        r.error_code = ERR_TIMEOUTS;
                        end_session();
                    end else begin
                        r.status = ST_CONTINUE;
                    end
                end
            end else if (!active) begin
                if (l < REQ_MIN_LEN)
                    err = ERR_LENGTH;
                else if (it.pkt_opcode != REQ_OPCODE)
                    err = ERR_OPCODE;
                else if (n == 0 || n >= l - HDR_BYTES)
                    err = ERR_NAME;
                else if (m == 0 || m > l - HDR_BYTES - n)
                    err = ERR_MODE;
                if (err != ERR_NONE) begin
                    r.status     = ST_ABORT;
                    r.error_code = err;
                    end_session();
                end else begin
                    active     = 1'b1;
                    acked      = '0;
                    timeouts   = '0;
                    r.ack_send = 1'b1;
                    r.status   = ST_CONTINUE;
                end
            end else begin
                timeouts = '0;
                if (l < HDR_BYTES || l > FULL_LEN)
                    err = ERR_LENGTH;
                else if (it.pkt_opcode != DAT_OPCODE)
                    err = ERR_OPCODE;
                else if (int'(it.data_blk) != int'(acked) + 1)
                    err = ERR_BLOCK;
                if (err != ERR_NONE) begin
                    r.status     = ST_ABORT;
                    r.error_code = err;
                    end_session();
                end else begin
                    acked       = acked + 1'b1;
                    r.ack_send  = 1'b1;
                    r.ack_block = acked;
                    r.write_en  = 1'b1;
                    r.write_len = LEN_W'(l - HDR_BYTES);
                    if (l < FULL_LEN) begin
                        r.status = ST_DONE;
                        end_session();
                    end else begin
                        r.status = ST_CONTINUE;
                    end
                end
            end
            due_results.push_back(r);
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t ns: result beat with none expected, actual %h", $time, d);
                mismatch_count++;
                return;
            end
            want = due_results.pop_front();
            compare("ack_send",   int'(want.ack_send),   int'(d[0]));
            compare("ack_block",  int'(want.ack_block),  int'(d[16:1]));
            compare("write_en",   int'(want.write_en),   int'(d[17]));
            compare("write_len",  int'(want.write_len),  int'(d[27:18]));
            compare("status",     int'(want.status),     int'(d[29:28]));
            compare("error_code", int'(want.error_code), int'(d[32:30]));
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data;

    session_tracker tracker;
    int             send_idle_pct;
    int             recv_idle_pct;

    tftp_write_receiver_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    function automatic t_item mk(logic op, int len, int opc, int blk, int nlen, int mlen);
        t_item it;
        it.op         = op;
        it.pkt_len    = LEN_W'(len);
        it.pkt_opcode = WORD_W'(opc);
        it.data_blk   = WORD_W'(blk);
        it.name_len   = LEN_W'(nlen);
        it.mode_len   = LEN_W'(mlen);
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    sel;
        int    len;
        int    nlen;
        sel = $urandom_range(99);
        it  = mk(OP_PACKET, $urandom_range(1023), $urandom, $urandom,
                 $urandom_range(1023), $urandom_range(1023));
        if (sel < 8) begin
            it.op = 1'($urandom_range(1));
        end else if (sel < 20) begin
            it.op = OP_TIMEOUT;
        end else if (!tracker.active) begin
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(6, 12) : $urandom_range(6, FULL_LEN);
                nlen = $urandom_range(1, len - 5);
                it.pkt_len    = LEN_W'(len);
                it.pkt_opcode = REQ_OPCODE;
                it.name_len   = LEN_W'(nlen);
                it.mode_len   = LEN_W'($urandom_range(1, len - HDR_BYTES - nlen));
            end else begin
                it.pkt_len = LEN_W'($urandom_range(FULL_LEN));
                if ($urandom_range(1)) it.pkt_opcode = REQ_OPCODE;
                it.name_len = LEN_W'($urandom_range(514));
                it.mode_len = LEN_W'($urandom_range(514));
            end
        end else begin
            it.pkt_opcode = DAT_OPCODE;
            it.data_blk   = tracker.acked + 1'b1;
            it.pkt_len    = ($urandom_range(99) < 70) ? LEN_W'(FULL_LEN)
                                                      : LEN_W'($urandom_range(HDR_BYTES, FULL_LEN - 1));
            if ($urandom_range(99) < 12) begin
                case ($urandom_range(2))
                    0: it.pkt_len = $urandom_range(1) ? LEN_W'($urandom_range(HDR_BYTES - 1))
                                                      : LEN_W'($urandom_range(FULL_LEN + 1, 1023));
                    1: it.pkt_opcode = $urandom_range(1) ? REQ_OPCODE : WORD_W'($urandom);
                    default: it.data_blk = it.data_blk + WORD_W'($urandom_range(1, 65535));
                endcase
            end
        end
        return it;
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.op;
        s_tdata  = {2'b00, it.mode_len, it.name_len, it.data_blk, it.pkt_opcode, it.pkt_len};
        do @(posedge i_clk); while (!s_tready);
        tracker.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] v);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_limit(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(int count);
        t_item it;
        logic  ignored;
        int    n;
        n = 0;
        while (n < count) begin
            it      = random_item();
            ignored = (it.op == OP_TIMEOUT) && !tracker.active;
            send_item(it);
            if (!ignored) n++;
        end
    endtask

    initial begin
        tracker       = new();
        send_idle_pct = 36;
        recv_idle_pct = 86;
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: idle timeout, each request check, each data check, done paths
        send_item(mk(OP_TIMEOUT, 1023, 65535, 65535, 1023, 1023));
        send_item(mk(OP_PACKET, 5, REQ_OPCODE, 0, 1, 0));
        send_item(mk(OP_PACKET, 20, DAT_OPCODE, 0, 3, 3));
        send_item(mk(OP_PACKET, 20, REQ_OPCODE, 0, 0, 3));
        send_item(mk(OP_PACKET, 20, REQ_OPCODE, 0, 16, 3));
        send_item(mk(OP_PACKET, 20, REQ_OPCODE, 0, 5, 0));
        send_item(mk(OP_PACKET, 20, REQ_OPCODE, 0, 5, 12));
        send_item(mk(OP_PACKET, 6, REQ_OPCODE, 65535, 1, 1));
        send_item(mk(OP_PACKET, 3, DAT_OPCODE, 1, 0, 0));
        send_item(mk(OP_PACKET, FULL_LEN, REQ_OPCODE, 0, 511, 1));
        send_item(mk(OP_PACKET, FULL_LEN + 1, DAT_OPCODE, 1, 0, 0));
        send_item(mk(OP_PACKET, 1023, REQ_OPCODE, 0, 8, 1011));
        send_item(mk(OP_PACKET, FULL_LEN, REQ_OPCODE, 1, 0, 0));
        send_item(mk(OP_PACKET, 30, REQ_OPCODE, 0, 10, 5));
        send_item(mk(OP_PACKET, FULL_LEN, DAT_OPCODE, 2, 0, 0));
        send_item(mk(OP_PACKET, 30, REQ_OPCODE, 0, 10, 5));
        send_item(mk(OP_PACKET, FULL_LEN, DAT_OPCODE, 1, 1023, 1023));
        send_item(mk(OP_TIMEOUT, 0, 0, 0, 0, 0));
        send_item(mk(OP_PACKET, HDR_BYTES, DAT_OPCODE, 2, 0, 0));
        send_item(mk(OP_PACKET, 30, REQ_OPCODE, 0, 10, 5));
        send_item(mk(OP_PACKET, FULL_LEN - 1, DAT_OPCODE, 1, 0, 0));

        // zero limit: first timeout aborts and still re-sends the ack
        write_limit(8'd0);
        send_item(mk(OP_PACKET, 30, REQ_OPCODE, 0, 10, 5));
        send_item(mk(OP_TIMEOUT, 0, 0, 0, 0, 0));

        write_limit(8'd2);
        run_random(140);

        send_idle_pct = 86;
        recv_idle_pct = 36;
        write_limit(8'd1);
        run_random(140);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(8'd255);
        run_random(140);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("tftp_write_receiver_core: match");
        else
            $display("tftp_write_receiver_core: mismatch");
        $finish;
    end

    initial begin
        #5ms;
        $display("tftp_write_receiver_core: mismatch");
        $finish;
    end

endmodule
